@@ sv/gfdd_pkg.sv @@
// Shared types and constants of the grid finite-difference derivative core.
// No dependencies; imported by gfdd_acc and the top level.
package gfdd_pkg;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_LAST = 5'b00100,
        S_PUT  = 5'b01000,
        S_BAD  = 5'b10000
    } t_state;

    // Control from the sequencer to the accumulator datapath
    typedef struct packed {
        logic       clr;    // start a new sum
        logic       add;    // read data of a corner arrives this cycle
        logic       neg;    // that corner is subtracted
        logic [1:0] shift;  // final scale, log2
    } t_acc_ctl;

    localparam logic       ACT_WRITE = 1'b0;
    localparam logic       ACT_QUERY = 1'b1;

    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;

    localparam logic [2:0] KIND_LAST = 3'd6;
    localparam int         DERIV_LIMIT = 2097152;
    localparam int         DERIV_W = 23;

    // Axis mask per derivative kind: bit 0 x, bit 1 y, bit 2 z
    function automatic logic [2:0] kind_axes(input logic [2:0] kind);
        logic [2:0] ax;
        case (kind)
            3'd0:    ax = 3'b001;
            3'd1:    ax = 3'b010;
            3'd2:    ax = 3'b100;
            3'd3:    ax = 3'b011;
            3'd4:    ax = 3'b101;
            3'd5:    ax = 3'b110;
            3'd6:    ax = 3'b111;
            default: ax = 3'b001;
        endcase
        return ax;
    endfunction

endpackage

@@ sv/grid_finite_difference_derivatives_core.sv @@
// Top level: stream ports, size registers, query sequencer.
// Depends on gfdd_pkg, gfdd_store, gfdd_acc.
//
//  channel   dir  handshake                      payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata, tuser (action)
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata, tuser, tlast
//  cfg       in   i_cfg_valid/o_cfg_ready         i_cfg_index, i_cfg_data
//
// A word is taken only while the sequencer is idle. A query reads its 26 neighbor
// samples one per cycle through the single store read port; each of its seven
// results then passes S_LAST and S_PUT. An out-of-grid query gives one bad word
// through S_BAD. Output stalls hold the sequencer only when the output register is
// still full. Reset clears control and sets the sizes to 16; the store is not
// cleared and holds nothing valid until written.
module grid_finite_difference_derivatives_core import gfdd_pkg::*; #(
    parameter int MAX_DIM     = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // node_x, node_y, node_z, sample_x/y/z, 0 pad
    input  logic [0:0]  i_s_axis_tuser,   // action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // deriv_x, deriv_y, deriv_z, 0 pad
    output logic [3:0]  o_m_axis_tuser,   // bad_index, deriv_kind
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data
);

    localparam int IW = $clog2(MAX_DIM);
    localparam int AW = 3 * IW;
    localparam int SB = SAMPLE_BITS;

    typedef struct packed {
        logic [IW-1:0] hi;
        logic [IW-1:0] lo;
        logic          mid;   // interior node: weight one half
    } t_plan;

    function automatic logic [4:0] eff_size(input logic [4:0] raw);
        logic [4:0] s;
        if (raw < 5'd2) begin
            s = 5'd2;
        end else if ({3'b0, raw} > 8'(MAX_DIM)) begin
            s = 5'(MAX_DIM);
        end else begin
            s = raw;
        end
        return s;
    endfunction

    function automatic t_plan plan_axis(input logic [3:0] idx, input logic [4:0] size);
        t_plan p;
        if (idx == 4'd0) begin
            p.hi = IW'(1); p.lo = '0; p.mid = 1'b0;
        end else if ({1'b0, idx} == size - 5'd1) begin
            p.hi = IW'(size - 5'd1); p.lo = IW'(size - 5'd2); p.mid = 1'b0;
        end else begin
            p.hi = IW'({1'b0, idx} + 5'd1); p.lo = IW'({1'b0, idx} - 5'd1); p.mid = 1'b1;
        end
        return p;
    endfunction

    // input word fields
    logic [3:0]      w_nx, w_ny, w_nz;
    logic            w_act;
    logic [4:0]      w_sx, w_sy, w_sz;
    logic            w_inside, w_in_acc;
    assign w_nx  = i_s_axis_tdata[3:0];
    assign w_ny  = i_s_axis_tdata[7:4];
    assign w_nz  = i_s_axis_tdata[11:8];
    assign w_act = i_s_axis_tuser[0];

    logic [4:0] r_size_x, r_size_y, r_size_z;
    assign w_sx = eff_size(r_size_x);
    assign w_sy = eff_size(r_size_y);
    assign w_sz = eff_size(r_size_z);
    assign w_inside = ({1'b0, w_nx} < w_sx) && ({1'b0, w_ny} < w_sy) && ({1'b0, w_nz} < w_sz);

    t_state r_state, n_state;
    t_plan  r_px, r_py, r_pz;
    logic [IW-1:0] r_nx, r_ny, r_nz;
    logic [2:0]    r_kind, r_corner;
    logic          r_rd_pend, r_rd_neg;
    logic          r_mv, r_m_last, r_m_bad;
    logic [2:0]    r_m_kind;
    logic [DERIV_W-1:0] r_dx, r_dy, r_dz;

    logic [2:0]    w_ax, w_next_corner, w_mid_ax;
    logic [1:0]    w_shift;
    logic          w_out_free, w_load_res, w_load_bad;
    logic          w_re, w_we;
    logic [AW-1:0] w_raddr, w_waddr;
    logic [IW-1:0] w_cx, w_cy, w_cz;
    logic [3*SB-1:0] w_wdata, w_rdata;
    logic [DERIV_W-1:0] w_dx, w_dy, w_dz;
    t_acc_ctl      w_ctl;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_ax = kind_axes(r_kind);
    // next corner whose set bits are a subset of the axis mask; wraps to 0 when done
    assign w_next_corner = ((r_corner | ~w_ax) + 3'd1) & w_ax;
    assign w_mid_ax = w_ax & {r_pz.mid, r_py.mid, r_px.mid};
    assign w_shift  = 2'd3 - (2'({1'b0, w_mid_ax[0]}) + 2'({1'b0, w_mid_ax[1]})
                              + 2'({1'b0, w_mid_ax[2]}));

    assign w_cx = (w_ax[0]) ? (r_corner[0] ? r_px.lo : r_px.hi) : r_nx;
    assign w_cy = (w_ax[1]) ? (r_corner[1] ? r_py.lo : r_py.hi) : r_ny;
    assign w_cz = (w_ax[2]) ? (r_corner[2] ? r_pz.lo : r_pz.hi) : r_nz;
    assign w_raddr = {w_cx, w_cy, w_cz};
    assign w_re    = (r_state == S_RD);

    assign w_we    = w_in_acc && (w_act == ACT_WRITE) && w_inside;
    assign w_waddr = {IW'(w_nx), IW'(w_ny), IW'(w_nz)};
    assign w_wdata = {SB'(i_s_axis_tdata[59:44]), SB'(i_s_axis_tdata[43:28]),
                      SB'(i_s_axis_tdata[27:12])};

    assign w_out_free = !r_mv || i_m_axis_tready;
    assign w_load_res = (r_state == S_PUT) && w_out_free;
    assign w_load_bad = (r_state == S_BAD) && w_out_free;

    always_comb begin
        w_ctl.clr   = w_load_res || (w_in_acc && (w_act == ACT_QUERY));
        w_ctl.add   = r_rd_pend;
        w_ctl.neg   = r_rd_neg;
        w_ctl.shift = w_shift;
    end

    gfdd_store #(.AW(AW), .DW(3 * SB)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    gfdd_acc #(.SB(SB)) u_acc (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_rdata   (w_rdata),
        .o_deriv_x (w_dx),
        .o_deriv_y (w_dy),
        .o_deriv_z (w_dz)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (w_act == ACT_QUERY)) begin
                    n_state = w_inside ? S_RD : S_BAD;
                end
            end
            S_RD: begin
                if (w_next_corner == 3'd0) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: n_state = S_PUT;
            S_PUT: begin
                if (w_out_free) begin
                    n_state = (r_kind == KIND_LAST) ? S_IDLE : S_RD;
                end
            end
            S_BAD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_size_x  <= 5'd16;
            r_size_y  <= 5'd16;
            r_size_z  <= 5'd16;
            r_rd_pend <= 1'b0;
            r_mv      <= 1'b0;
            r_kind    <= '0;
            r_corner  <= '0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= w_re;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SIZE_X: r_size_x <= i_cfg_data;
                    CFG_SIZE_Y: r_size_y <= i_cfg_data;
                    CFG_SIZE_Z: r_size_z <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_in_acc) begin
                r_kind   <= '0;
                r_corner <= '0;
            end else if (r_state == S_RD) begin
                r_corner <= w_next_corner;
            end else if (w_load_res) begin
                r_kind   <= r_kind + 3'd1;
                r_corner <= '0;
            end
            if (w_load_res || w_load_bad) begin
                r_mv <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_mv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_neg <= ^r_corner;
        if (w_in_acc) begin
            r_nx <= IW'(w_nx);
            r_ny <= IW'(w_ny);
            r_nz <= IW'(w_nz);
            r_px <= plan_axis(w_nx, w_sx);
            r_py <= plan_axis(w_ny, w_sy);
            r_pz <= plan_axis(w_nz, w_sz);
        end
        if (w_load_res) begin
            r_m_bad  <= 1'b0;
            r_m_kind <= r_kind;
            r_m_last <= (r_kind == KIND_LAST);
            r_dx     <= w_dx;
            r_dy     <= w_dy;
            r_dz     <= w_dz;
        end else if (w_load_bad) begin
            r_m_bad  <= 1'b1;
            r_m_kind <= '0;
            r_m_last <= 1'b1;
            r_dx     <= '0;
            r_dy     <= '0;
            r_dz     <= '0;
        end
    end

    assign o_m_axis_tvalid = r_mv;
    assign o_m_axis_tdata  = {3'b000, r_dz, r_dy, r_dx};
    assign o_m_axis_tuser  = {r_m_kind, r_m_bad};
    assign o_m_axis_tlast  = r_m_last;

endmodule

@@ sv/gfdd_store.sv @@
// Grid sample store: single-port-write, single-port-read synchronous memory.
// Read data registered. No dependencies.
module gfdd_store #(
    parameter int AW = 12,
    parameter int DW = 48
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/gfdd_acc.sv @@
// Corner-sum accumulator for three components, with scale and saturation.
// Depends on gfdd_pkg (t_acc_ctl, DERIV_LIMIT, DERIV_W).
module gfdd_acc import gfdd_pkg::*; #(
    parameter int SB = 16
) (
    input  logic                i_clk,
    input  t_acc_ctl            i_ctl,
    input  logic [3*SB-1:0]     i_rdata,
    output logic [DERIV_W-1:0]  o_deriv_x,
    output logic [DERIV_W-1:0]  o_deriv_y,
    output logic [DERIV_W-1:0]  o_deriv_z
);

    localparam int AW = SB + 3;              // sum of up to eight samples
    localparam int PW = AW + 3;              // after scale by up to 8
    localparam int CW = (PW > DERIV_W) ? PW : DERIV_W;
    localparam logic signed [CW-1:0] LIM_P = CW'(DERIV_LIMIT);
    localparam logic signed [CW-1:0] LIM_N = -CW'(DERIV_LIMIT);

    logic signed [AW-1:0] r_acc [3];
    logic signed [AW-1:0] n_acc [3];
    logic [DERIV_W-1:0]   w_out [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [AW-1:0] smp;
            smp = AW'($signed(i_rdata[i*SB +: SB]));
            n_acc[i] = r_acc[i];
            if (i_ctl.clr) begin
                n_acc[i] = '0;
            end else if (i_ctl.add) begin
                n_acc[i] = i_ctl.neg ? r_acc[i] - smp : r_acc[i] + smp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_acc[i] <= n_acc[i];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [CW-1:0] prod;
            prod = CW'(r_acc[i]) <<< i_ctl.shift;
            if (prod > LIM_P) begin
                prod = LIM_P;
            end else if (prod < LIM_N) begin
                prod = LIM_N;
            end
            w_out[i] = prod[DERIV_W-1:0];
        end
    end

    assign o_deriv_x = w_out[0];
    assign o_deriv_y = w_out[1];
    assign o_deriv_z = w_out[2];

endmodule

@@ tb/tb_grid_finite_difference_derivatives_core.sv @@
// Testbench of the grid finite-difference derivative core: stores samples, queries
// derivatives and checks every result word against a behavioral predictor.
// Depends on gfdd_pkg and grid_finite_difference_derivatives_core.
`timescale 1ns / 1ps

module tb_grid_finite_difference_derivatives_core import gfdd_pkg::*; ();

    typedef struct packed {
        logic        bad;
        logic [2:0]  kind;
        logic [22:0] dx;
        logic [22:0] dy;
        logic [22:0] dz;
        logic        last;
    } t_deriv;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata = '0;
    logic [0:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [71:0] o_m_axis_tdata;
    logic [3:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [4:0]  i_cfg_data = '0;

    grid_finite_difference_derivatives_core dut (.*);

    initial forever #2 i_clk = ~i_clk;

    // predictor state
    logic signed [15:0] grid_val [0:4095][0:2];
    bit                 grid_written [0:4095];
    logic [4:0]         dim_raw [0:2];
    t_deriv             deriv_queue [$];
    int                 err_count = 0;
    int                 idle_pct = 36;
    bit                 hold_rx = 1'b0;
    int                 quiet_cycles = 0;

    function automatic int eff_dim(input int a);
        int r;
        r = dim_raw[a];
        if (r < 2) r = 2;
        if (r > 16) r = 16;
        return r;
    endfunction

    function automatic int cell_idx(input int x, input int y, input int z);
        return (x * 16 + y) * 16 + z;
    endfunction

    function automatic logic [22:0] sat23(input longint v);
        if (v > DERIV_LIMIT) v = DERIV_LIMIT;
        if (v < -DERIV_LIMIT) v = -DERIV_LIMIT;
        return v[22:0];
    endfunction

    // Expected results of one accepted word
    task automatic predict_word(input logic act, input int nx, input int ny, input int nz,
                                input logic [15:0] sx, input logic [15:0] sy,
                                input logic [15:0] sz);
        int hi [0:2];
        int lo [0:2];
        int mul [0:2];
        int nd [0:2];
        int p [0:2];
        int ax, sc, k, crn, a, c;
        bit in_grid;
        longint acc [0:2];
        longint sgn;
        t_deriv r;
        nd[0] = nx; nd[1] = ny; nd[2] = nz;
        in_grid = nx < eff_dim(0) && ny < eff_dim(1) && nz < eff_dim(2);
        if (act == ACT_WRITE) begin
            if (in_grid) begin
                c = cell_idx(nx, ny, nz);
                grid_val[c][0] = sx; grid_val[c][1] = sy; grid_val[c][2] = sz;
                grid_written[c] = 1'b1;
            end
            return;
        end
        if (!in_grid) begin
            r = '0; r.bad = 1'b1; r.last = 1'b1;
            deriv_queue.push_back(r);
            return;
        end
        for (a = 0; a < 3; a++) begin
            if (nd[a] == 0) begin
                hi[a] = 1; lo[a] = 0; mul[a] = 2;
            end else if (nd[a] == eff_dim(a) - 1) begin
                hi[a] = nd[a]; lo[a] = nd[a] - 1; mul[a] = 2;
            end else begin
                hi[a] = nd[a] + 1; lo[a] = nd[a] - 1; mul[a] = 1;
            end
        end
        for (k = 0; k < 7; k++) begin
            ax = kind_axes(k[2:0]);
            sc = 8;
            for (a = 0; a < 3; a++) if (ax[a]) sc = sc * mul[a] / 2;
            for (c = 0; c < 3; c++) acc[c] = 0;
            for (crn = 0; crn < 8; crn++) begin
                if ((crn & ~ax) != 0) continue;
                sgn = 1;
                for (a = 0; a < 3; a++) begin
                    p[a] = nd[a];
                    if (ax[a]) begin
                        if (crn[a]) begin
                            p[a] = lo[a]; sgn = -sgn;
                        end else p[a] = hi[a];
                    end
                end
                for (c = 0; c < 3; c++)
                    acc[c] += sgn * longint'(grid_val[cell_idx(p[0], p[1], p[2])][c]);
            end
            r.bad = 1'b0; r.kind = k[2:0];
            r.dx = sat23(acc[0] * sc); r.dy = sat23(acc[1] * sc);
            r.dz = sat23(acc[2] * sc);
            r.last = (k == 6);
            deriv_queue.push_back(r);
        end
    endtask

    // valid stays high after the accept; the next word, an idle cycle or drain drops it
    task automatic send_word(input logic act, input int nx, input int ny, input int nz,
                             input logic [15:0] sx, input logic [15:0] sy,
                             input logic [15:0] sz);
        while ($urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= act;
        i_s_axis_tdata  <= {4'h0, sz, sy, sx, nz[3:0], ny[3:0], nx[3:0]};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_word(act, nx, ny, nz, sx, sy, sz);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
        i_cfg_valid <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        dim_raw[idx] = val;
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (deriv_queue.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic set_dims(input logic [4:0] x, input logic [4:0] y, input logic [4:0] z);
        drain();
        write_reg(CFG_SIZE_X, x); write_reg(CFG_SIZE_Y, y); write_reg(CFG_SIZE_Z, z);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic fill_grid(input bit extreme);
        int x, y, z;
        logic [15:0] v [0:2];
        for (x = 0; x < eff_dim(0); x++)
            for (y = 0; y < eff_dim(1); y++)
                for (z = 0; z < eff_dim(2); z++) begin
                    for (int c = 0; c < 3; c++)
                        v[c] = extreme ? (((x + y + z + c) & 1) ? 16'h8000 : 16'h7fff)
                                       : 16'($urandom);
                    send_word(ACT_WRITE, x, y, z, v[0], v[1], v[2]);
                end
    endtask

    // random query of a node inside the grid; callers fill its neighbors first
    task automatic rand_query();
        int x, y, z;
        x = $urandom_range(eff_dim(0) - 1);
        y = $urandom_range(eff_dim(1) - 1);
        z = $urandom_range(eff_dim(2) - 1);
        send_word(ACT_QUERY, x, y, z, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic test_directed();
        set_dims(5'd2, 5'd2, 5'd2);
        fill_grid(1'b1);
        send_word(ACT_QUERY, 0, 0, 0, '0, '0, '0);
        send_word(ACT_QUERY, 1, 1, 1, '0, '0, '0);
        send_word(ACT_QUERY, 2, 0, 0, '0, '0, '0);
        send_word(ACT_QUERY, 15, 15, 15, 16'hffff, 16'hffff, 16'hffff);
        send_word(ACT_WRITE, 0, 15, 0, 16'h1234, 16'h1, 16'h2);
        send_word(ACT_QUERY, 0, 1, 0, '0, '0, '0);
        // out-of-range size registers clamp
        set_dims(5'd0, 5'd31, 5'd3);
        send_word(ACT_QUERY, 0, 0, 0, '0, '0, '0);
        send_word(ACT_QUERY, 2, 0, 0, '0, '0, '0);
        send_word(ACT_QUERY, 0, 0, 3, '0, '0, '0);
        for (int x = 0; x < 2; x++)
            for (int y = 0; y < 2; y++)
                send_word(ACT_WRITE, x, y, 2, 16'($urandom), 16'($urandom), 16'($urandom));
        send_word(ACT_QUERY, 0, 0, 1, '0, '0, '0);
        send_word(ACT_QUERY, 0, 0, 2, '0, '0, '0);
    endtask

    task automatic test_random(input int n);
        set_dims(5'd3 + 5'($urandom_range(1)), 5'd3, 5'd3);
        fill_grid(1'b0);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 2)
                send_word(ACT_QUERY, $urandom_range(15), $urandom_range(15),
                          $urandom_range(15), '0, '0, '0);
            else if ($urandom_range(9) < 3)
                send_word(ACT_WRITE, $urandom_range(15), $urandom_range(15),
                          $urandom_range(15), 16'($urandom), 16'($urandom), 16'($urandom));
            else rand_query();
        end
    endtask

    // grid written over x, y, z 0..2 by the random test
    task automatic test_full_grid();
        set_dims(5'd16, 5'd16, 5'd16);
        send_word(ACT_QUERY, 0, 0, 0, '0, '0, '0);
        send_word(ACT_QUERY, 1, 1, 1, '0, '0, '0);
        send_word(ACT_QUERY, 0, 1, 1, '0, '0, '0);
        send_word(ACT_QUERY, 1, 1, 0, '0, '0, '0);
        send_word(ACT_QUERY, 1, 0, 1, '0, '0, '0);
    endtask

    // 2x3x2 grid lies inside the region the random test filled
    task automatic test_backpressure();
        set_dims(5'd2, 5'd3, 5'd2);
        hold_rx = 1'b1;
        idle_pct = 0;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            begin
                for (int i = 0; i < 6; i++) rand_query();
                i_s_axis_tvalid <= 1'b0;
            end
        join
        for (int i = 0; i < 10; i++) rand_query();
        idle_pct = 36;
    endtask

    task automatic test_no_idle(input int n);
        idle_pct = 0;
        for (int i = 0; i < n; i++) rand_query();
        idle_pct = 36;
    endtask

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) i_m_axis_tready <= 1'b0;
        else i_m_axis_tready <= !hold_rx && ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        t_deriv got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.bad = o_m_axis_tuser[0]; got.kind = o_m_axis_tuser[3:1];
            got.dx = o_m_axis_tdata[22:0]; got.dy = o_m_axis_tdata[45:23];
            got.dz = o_m_axis_tdata[68:46]; got.last = o_m_axis_tlast;
            if (deriv_queue.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                err_count++;
            end else begin
                want = deriv_queue.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    err_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("FAIL grid_finite_difference_derivatives_core");
            $finish;
        end
    end

    initial begin
        for (int c = 0; c < 4096; c++) begin
            grid_val[c][0] = '0; grid_val[c][1] = '0; grid_val[c][2] = '0;
        end
        dim_raw[0] = 5'd16; dim_raw[1] = 5'd16; dim_raw[2] = 5'd16;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(30);
        test_backpressure();
        test_no_idle(10);
        test_full_grid();
        drain();
        if (err_count == 0 && deriv_queue.size() == 0)
            $display("PASS grid_finite_difference_derivatives_core");
        else
            $display("FAIL grid_finite_difference_derivatives_core");
        $finish;
    end

endmodule
